// ----- src/cts_pkg.sv -----
// Shared types, constants and the keyword lookup for the token scanner.
package cts_pkg;

    // Token text buffer size; bounds the reported token length
    localparam int TOKEN_BUFFER_BYTES = 256;
    localparam int LEN_CAP_INT = (TOKEN_BUFFER_BYTES - 1 < 255) ? (TOKEN_BUFFER_BYTES - 1) : 255;
    localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

    localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;
    localparam logic [2:0]  NO_KEYWORD = 3'd7;
    localparam int          KW_COUNT = 7;

    // Result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        TC_EOF     = 4'd0,
        TC_IDENT   = 4'd1,
        TC_INT     = 4'd2,
        TC_KEYWORD = 4'd3,
        TC_ARITH   = 4'd4,
        TC_REL     = 4'd5,
        TC_LOGIC   = 4'd6,
        TC_BITWISE = 4'd7,
        TC_ASSIGN  = 4'd8,
        TC_LPAREN  = 4'd9,
        TC_RPAREN  = 4'd10,
        TC_LBRACE  = 4'd11,
        TC_RBRACE  = 4'd12,
        TC_SEMI    = 4'd13,
        TC_ERROR   = 4'd14
    } tok_class_t;

    // One result word
    typedef struct packed {
        tok_class_t  cls;
        logic [7:0]  len;
        logic [7:0]  first;
        logic [2:0]  kw;
        logic [23:0] line;
        logic        last;
    } tok_t;

    // Tokens handed from the scanner to the result queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok_a;
        tok_t       tok_b;
    } push_t;

    // Keyword text, first character in the low byte, zero padded
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        {16'h0, "tni"},
        {"taolf"},
        {8'h0, "rahc"},
        {16'h0, "rof"},
        {"elihw"},
        {24'h0, "fi"},
        {8'h0, "esle"}
    };
    localparam logic [7:0] KW_LEN [KW_COUNT] = '{
        8'd3, 8'd5, 8'd4, 8'd3, 8'd5, 8'd2, 8'd4
    };

    // Index of the keyword matching a pending identifier, NO_KEYWORD if none
    function automatic logic [2:0] kw_index(input logic [39:0] prefix, input logic [7:0] len);
        logic [2:0] idx;
        idx = NO_KEYWORD;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (len == KW_LEN[k] && prefix == KW_TEXT[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/cts_scan.sv -----
// Input register, scan state and per-byte token classification.
module cts_scan
    import cts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    input  logic       room,
    output push_t      push
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_IDENT, PH_NUMBER, PH_PLUS, PH_MINUS, PH_MULDIV, PH_EQ,
        PH_LTGT, PH_SHIFT, PH_BANG, PH_AMP, PH_PIPE, PH_CARET
    } phase_t;

    logic        item_valid_reg;
    logic [7:0]  byte_reg;
    logic        end_reg;

    phase_t      phase_reg,  phase_next;
    logic [7:0]  len_reg,    len_next;
    logic [39:0] prefix_reg, prefix_next;
    logic [7:0]  first_reg,  first_next;
    logic [23:0] line_reg,   line_next;

    logic        fire;
    logic [7:0]  c;
    logic        c_alpha, c_digit, c_is_eq, c_is_first;
    logic [7:0]  add_len;
    logic [39:0] add_prefix;
    logic [2:0]  kw;

    logic        absorbed, ext_finish;
    tok_class_t  ext_class;
    phase_t      ext_phase;
    tok_class_t  flush_class;

    logic        st_single, st_start, st_newline;
    tok_class_t  st_class;
    phase_t      st_phase;

    logic        a_valid, b_valid;
    tok_t        tok_a, tok_b;

    // Input word stage
    assign fire     = item_valid_reg && room;
    assign in_ready = !item_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= text_byte;
            end_reg  <= end_of_text;
        end
    end

    // Character helpers
    assign c          = byte_reg;
    assign c_alpha    = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign c_digit    = (c >= "0" && c <= "9");
    assign c_is_eq    = (c == "=");
    assign c_is_first = (c == first_reg);
    assign add_len    = (len_reg < LEN_CAP) ? len_reg + 8'd1 : len_reg;
    assign kw         = kw_index(prefix_reg, len_reg);

    // Append the current byte to the keyword prefix while it is short
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            add_prefix[8*i +: 8] = (len_reg == 8'(i)) ? c : prefix_reg[8*i +: 8];
        end
    end

    // Can the pending token absorb this byte
    always_comb
    begin
        absorbed   = 1'b0;
        ext_finish = 1'b0;
        ext_class  = TC_ARITH;
        ext_phase  = phase_reg;
        unique case (phase_reg)
            PH_IDENT:
            begin
                absorbed = c_alpha || c_digit;
            end
            PH_NUMBER:
            begin
                absorbed = c_digit;
            end
            PH_PLUS, PH_MINUS:
            begin
                absorbed   = c_is_eq || c_is_first;
                ext_finish = 1'b1;
                ext_class  = c_is_eq ? TC_ASSIGN : TC_ARITH;
            end
            PH_MULDIV, PH_SHIFT, PH_CARET:
            begin
                absorbed   = c_is_eq;
                ext_finish = 1'b1;
                ext_class  = TC_ASSIGN;
            end
            PH_EQ, PH_BANG:
            begin
                absorbed   = c_is_eq;
                ext_finish = 1'b1;
                ext_class  = TC_REL;
            end
            PH_LTGT:
            begin
                absorbed   = c_is_eq || c_is_first;
                ext_finish = c_is_eq;
                ext_class  = TC_REL;
                ext_phase  = PH_SHIFT;
            end
            PH_AMP, PH_PIPE:
            begin
                absorbed   = c_is_eq || c_is_first;
                ext_finish = 1'b1;
                ext_class  = c_is_eq ? TC_ASSIGN : TC_LOGIC;
            end
            default:
            begin
                absorbed = 1'b0;
            end
        endcase
    end

    // Class of the pending token when it ends without the current byte
    always_comb
    begin
        unique case (phase_reg)
            PH_IDENT:                             flush_class = (kw != NO_KEYWORD) ? TC_KEYWORD : TC_IDENT;
            PH_NUMBER:                            flush_class = TC_INT;
            PH_PLUS, PH_MINUS, PH_MULDIV:         flush_class = TC_ARITH;
            PH_EQ:                                flush_class = TC_ASSIGN;
            PH_LTGT:                              flush_class = TC_REL;
            PH_BANG:                              flush_class = TC_LOGIC;
            PH_SHIFT, PH_AMP, PH_PIPE, PH_CARET:  flush_class = TC_BITWISE;
            default:                              flush_class = TC_ERROR;
        endcase
    end

    // What a byte does when no token is pending
    always_comb
    begin
        st_single  = 1'b0;
        st_start   = 1'b0;
        st_newline = 1'b0;
        st_class   = TC_ERROR;
        st_phase   = PH_IDLE;
        if (c_alpha)
        begin
            st_start = 1'b1;
            st_phase = PH_IDENT;
        end
        else if (c_digit)
        begin
            st_start = 1'b1;
            st_phase = PH_NUMBER;
        end
        else
        begin
            unique case (c)
                " ", "\t": ;
                "\n":      st_newline = 1'b1;
                "(":       begin st_single = 1'b1; st_class = TC_LPAREN;  end
                ")":       begin st_single = 1'b1; st_class = TC_RPAREN;  end
                "{":       begin st_single = 1'b1; st_class = TC_LBRACE;  end
                "}":       begin st_single = 1'b1; st_class = TC_RBRACE;  end
                ";":       begin st_single = 1'b1; st_class = TC_SEMI;    end
                "~":       begin st_single = 1'b1; st_class = TC_BITWISE; end
                "+":       begin st_start = 1'b1; st_phase = PH_PLUS;   end
                "-":       begin st_start = 1'b1; st_phase = PH_MINUS;  end
                "*", "/", "%":
                           begin st_start = 1'b1; st_phase = PH_MULDIV; end
                "=":       begin st_start = 1'b1; st_phase = PH_EQ;     end
                "<", ">":  begin st_start = 1'b1; st_phase = PH_LTGT;   end
                "!":       begin st_start = 1'b1; st_phase = PH_BANG;   end
                "&":       begin st_start = 1'b1; st_phase = PH_AMP;    end
                "|":       begin st_start = 1'b1; st_phase = PH_PIPE;   end
                "^":       begin st_start = 1'b1; st_phase = PH_CARET;  end
                default:   begin st_single = 1'b1; st_class = TC_ERROR; end
            endcase
        end
    end

    // Tokens and next state for the word in the input stage
    always_comb
    begin
        logic do_start;
        do_start    = 1'b0;
        a_valid     = 1'b0;
        b_valid     = 1'b0;
        phase_next  = phase_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        first_next  = first_reg;
        line_next   = line_reg;

        // pending token word, all tokens carry the line before this byte
        tok_a.cls   = flush_class;
        tok_a.len   = len_reg;
        tok_a.first = first_reg;
        tok_a.kw    = (phase_reg == PH_IDENT) ? kw : NO_KEYWORD;
        tok_a.line  = line_reg;
        tok_a.last  = 1'b0;

        tok_b.cls   = st_class;
        tok_b.len   = 8'd1;
        tok_b.first = c;
        tok_b.kw    = NO_KEYWORD;
        tok_b.line  = line_reg;
        tok_b.last  = 1'b1;

        if (end_reg)
        begin
            a_valid     = (phase_reg != PH_IDLE);
            b_valid     = 1'b1;
            tok_b.cls   = TC_EOF;
            tok_b.len   = 8'd0;
            tok_b.first = 8'd0;
            phase_next  = PH_IDLE;
            len_next    = 8'd0;
            prefix_next = 40'd0;
            first_next  = 8'd0;
        end
        else
        begin
            if (phase_reg == PH_IDLE)
            begin
                do_start = 1'b1;
            end
            else if (absorbed && ext_finish)
            begin
                a_valid     = 1'b1;
                tok_a.cls   = ext_class;
                tok_a.len   = add_len;
                tok_a.kw    = NO_KEYWORD;
                phase_next  = PH_IDLE;
                len_next    = 8'd0;
                prefix_next = 40'd0;
                first_next  = 8'd0;
            end
            else if (absorbed)
            begin
                phase_next  = ext_phase;
                len_next    = add_len;
                prefix_next = add_prefix;
            end
            else
            begin
                a_valid     = 1'b1;
                phase_next  = PH_IDLE;
                len_next    = 8'd0;
                prefix_next = 40'd0;
                first_next  = 8'd0;
                do_start    = 1'b1;
            end

            if (do_start)
            begin
                b_valid = st_single;
                if (st_start)
                begin
                    phase_next  = st_phase;
                    len_next    = 8'd1;
                    first_next  = c;
                    prefix_next = {32'd0, c};
                end
                if (st_newline && line_reg < LINE_MAX)
                begin
                    line_next = line_reg + 24'd1;
                end
            end
        end

        tok_a.last = !b_valid;
    end

    // Hand tokens to the queue, packed to the front
    always_comb
    begin
        push.count = fire ? (2'(a_valid) + 2'(b_valid)) : 2'd0;
        push.tok_a = a_valid ? tok_a : tok_b;
        push.tok_b = tok_b;
    end

    // Scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            len_reg    <= 8'd0;
            prefix_reg <= 40'd0;
            first_reg  <= 8'd0;
            line_reg   <= 24'd1;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            prefix_reg <= prefix_next;
            first_reg  <= first_next;
            line_reg   <= line_next;
        end
    end

endmodule

// ----- src/cts_queue.sv -----
// Result queue: takes up to two tokens a cycle, delivers one word a cycle while out_ready is high.
module cts_queue
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  push_t       push,
    output logic        room,
    output logic        out_valid,
    input  logic        out_ready,
    output tok_t        head
);

    tok_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign room      = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];
    assign count_next = count_reg + QCNT_W'(push.count) - QCNT_W'(pop);

    // Storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.tok_a;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + QPTR_W'(1)] <= push.tok_b;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push.count);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/c_subset_token_scanner_top.sv -----
// Top level of the streaming C subset token scanner.
//
//  Channel | Handshake            | Word fields
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_ready  | text_byte, end_of_text
//  output  | out_valid / out_ready| token_class, token_length, first_byte,
//          |                      | keyword_number, line_number, last_of_run
//
// One input word per cycle is taken while in_ready is high; a word is registered in
// the input stage, then scanned and pushed into the result queue ahead of the output.
// A word that yields two tokens gives two output words; the four-entry
// result queue sets how far the input can run ahead of a stalled output.
// Input is taken while the input register is empty or the queue has room for two.
// Reset (rst_n low) empties the queue, returns to idle and sets the line count to one.
module c_subset_token_scanner_top
    import cts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  token_class,
    output logic [7:0]  token_length,
    output logic [7:0]  first_byte,
    output logic [2:0]  keyword_number,
    output logic [23:0] line_number,
    output logic        last_of_run
);

    push_t push;
    logic  room;
    tok_t  head;

    cts_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .room        (room),
        .push        (push)
    );

    cts_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Output word fields
    assign token_class    = 4'(head.cls);
    assign token_length   = head.len;
    assign first_byte     = head.first;
    assign keyword_number = head.kw;
    assign line_number    = head.line;
    assign last_of_run    = head.last;

    // Tokens are only handed over when the queue has space for two
    assert property (@(posedge clk) disable iff (!rst_n) (push.count != 2'd0) |-> room)
        else $error("token pushed into full result queue");

    // The second token of a word is queued together with the first
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_of_run) |=> out_valid)
        else $error("second token of a word missing");

    // An end-of-text token is empty and closes its run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && token_class == 4'(TC_EOF)) |->
        (token_length == 8'd0 && first_byte == 8'd0 && last_of_run))
        else $error("malformed end-of-text token");

endmodule

// ----- tb/sv/tb_c_subset_token_scanner_top.sv -----
// Self-checking testbench for the C subset token scanner, with its own token predictor.
`timescale 1ns / 100ps

module tb_c_subset_token_scanner_top;
    import cts_pkg::*;

    // Predictor scan states
    typedef enum int {
        SC_IDLE, SC_NAME, SC_NUM, SC_PLUS, SC_MINUS, SC_MULDIV, SC_EQ,
        SC_LTGT, SC_SHIFT, SC_BANG, SC_AMP, SC_PIPE, SC_CARET
    } scan_state_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  token_class;
    logic [7:0]  token_length;
    logic [7:0]  first_byte;
    logic [2:0]  keyword_number;
    logic [23:0] line_number;
    logic        last_of_run;

    // Predictor state
    scan_state_t sc_state = SC_IDLE;
    logic [7:0]  tok_len = 8'd0;
    logic [39:0] tok_head = 40'd0;
    logic [7:0]  tok_first = 8'd0;
    logic [23:0] cur_line = 24'd1;
    int          step_tokens;

    tok_t tokens_due[$];

    int idle_pct = 30;
    int stall_left = 0;
    int failures = 0;
    int words_sent = 0;
    int ends_sent = 0;
    int tokens_checked = 0;

    string kw_words[7] = '{"int", "float", "char", "for", "while", "if", "else"};
    string op_words[38] = '{
        "+", "++", "+=", "-", "--", "-=", "*", "*=", "/", "/=", "%", "%=",
        "=", "==", "<", "<=", "<<", "<<=", ">", ">=", ">>", ">>=",
        "!", "!=", "&", "&&", "&=", "|", "||", "|=", "^", "^=", "~",
        "(", ")", "{", "}", ";"
    };

    c_subset_token_scanner_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .text_byte      (text_byte),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_class    (token_class),
        .token_length   (token_length),
        .first_byte     (first_byte),
        .keyword_number (keyword_number),
        .line_number    (line_number),
        .last_of_run    (last_of_run)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void note_failure(string what);
        failures++;
        if (failures <= 10)
        begin
            $display("[%0t] %s", $time, what);
        end
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit_tok(tok_class_t cls, logic [7:0] len, logic [7:0] first,
                                     logic [2:0] kw);
        tok_t t;
        t.cls   = cls;
        t.len   = len;
        t.first = first;
        t.kw    = kw;
        t.line  = cur_line;
        t.last  = 1'b0;
        tokens_due.push_back(t);
        step_tokens++;
    endfunction

    function automatic void start_pending(scan_state_t st, logic [7:0] c);
        sc_state  = st;
        tok_len   = 8'd1;
        tok_first = c;
        tok_head  = {32'd0, c};
    endfunction

    function automatic void clear_pending();
        sc_state  = SC_IDLE;
        tok_len   = 8'd0;
        tok_first = 8'd0;
        tok_head  = 40'd0;
    endfunction

    function automatic void close_pending(tok_class_t cls);
        emit_tok(cls, tok_len, tok_first, NO_KEYWORD);
        clear_pending();
    endfunction

    // Only the first five characters are kept for the keyword compare
    function automatic void grow(logic [7:0] c);
        if (tok_len < 8'd5)
        begin
            tok_head[int'(tok_len) * 8 +: 8] = c;
        end
        if (tok_len < LEN_CAP)
        begin
            tok_len++;
        end
    endfunction

    function automatic logic [2:0] keyword_code();
        logic [2:0] code;
        bit         same;
        code = NO_KEYWORD;
        for (int k = 6; k >= 0; k--)
        begin
            if (kw_words[k].len() == int'(tok_len))
            begin
                same = 1'b1;
                for (int i = 0; i < kw_words[k].len(); i++)
                begin
                    if (tok_head[8 * i +: 8] != kw_words[k][i])
                    begin
                        same = 1'b0;
                    end
                end
                if (same)
                begin
                    code = 3'(k);
                end
            end
        end
        return code;
    endfunction

    // Pending token ends without taking the current byte
    function automatic void flush_pending();
        logic [2:0] k;
        case (sc_state)
            SC_NAME:
            begin
                k = keyword_code();
                if (k != NO_KEYWORD)
                begin
                    emit_tok(TC_KEYWORD, tok_len, tok_first, k);
                    clear_pending();
                end
                else
                begin
                    close_pending(TC_IDENT);
                end
            end
            SC_NUM:                               close_pending(TC_INT);
            SC_PLUS, SC_MINUS, SC_MULDIV:         close_pending(TC_ARITH);
            SC_EQ:                                close_pending(TC_ASSIGN);
            SC_LTGT:                              close_pending(TC_REL);
            SC_BANG:                              close_pending(TC_LOGIC);
            SC_SHIFT, SC_AMP, SC_PIPE, SC_CARET:  close_pending(TC_BITWISE);
            default:                              sc_state = SC_IDLE;
        endcase
    endfunction

    // Try to extend the pending token; 1 when the byte was taken
    function automatic bit absorb(logic [7:0] c);
        case (sc_state)
            SC_NAME:
            begin
                if (is_letter(c) || is_digit_ch(c))
                begin
                    grow(c);
                    return 1'b1;
                end
            end
            SC_NUM:
            begin
                if (is_digit_ch(c))
                begin
                    grow(c);
                    return 1'b1;
                end
            end
            SC_PLUS, SC_MINUS, SC_AMP, SC_PIPE:
            begin
                if (c == "=")
                begin
                    grow(c);
                    close_pending(TC_ASSIGN);
                    return 1'b1;
                end
                if (c == tok_first)
                begin
                    grow(c);
                    close_pending((sc_state == SC_AMP || sc_state == SC_PIPE) ?
                                  TC_LOGIC : TC_ARITH);
                    return 1'b1;
                end
            end
            SC_MULDIV, SC_SHIFT, SC_CARET:
            begin
                if (c == "=")
                begin
                    grow(c);
                    close_pending(TC_ASSIGN);
                    return 1'b1;
                end
            end
            SC_EQ, SC_BANG:
            begin
                if (c == "=")
                begin
                    grow(c);
                    close_pending(TC_REL);
                    return 1'b1;
                end
            end
            SC_LTGT:
            begin
                if (c == "=")
                begin
                    grow(c);
                    close_pending(TC_REL);
                    return 1'b1;
                end
                if (c == tok_first)
                begin
                    grow(c);
                    sc_state = SC_SHIFT;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // A byte seen with nothing pending
    function automatic void begin_char(logic [7:0] c);
        case (c)
            " ", "\t": ;
            "\n":
            begin
                if (cur_line != LINE_MAX)
                begin
                    cur_line++;
                end
            end
            "(": emit_tok(TC_LPAREN, 8'd1, c, NO_KEYWORD);
            ")": emit_tok(TC_RPAREN, 8'd1, c, NO_KEYWORD);
            "{": emit_tok(TC_LBRACE, 8'd1, c, NO_KEYWORD);
            "}": emit_tok(TC_RBRACE, 8'd1, c, NO_KEYWORD);
            ";": emit_tok(TC_SEMI, 8'd1, c, NO_KEYWORD);
            "~": emit_tok(TC_BITWISE, 8'd1, c, NO_KEYWORD);
            "+": start_pending(SC_PLUS, c);
            "-": start_pending(SC_MINUS, c);
            "*", "/", "%": start_pending(SC_MULDIV, c);
            "=": start_pending(SC_EQ, c);
            "<", ">": start_pending(SC_LTGT, c);
            "!": start_pending(SC_BANG, c);
            "&": start_pending(SC_AMP, c);
            "|": start_pending(SC_PIPE, c);
            "^": start_pending(SC_CARET, c);
            default:
            begin
                if (is_letter(c))
                begin
                    start_pending(SC_NAME, c);
                end
                else if (is_digit_ch(c))
                begin
                    start_pending(SC_NUM, c);
                end
                else
                begin
                    emit_tok(TC_ERROR, 8'd1, c, NO_KEYWORD);
                end
            end
        endcase
    endfunction

    // Expected tokens for one accepted word
    function automatic void scan_word(logic [7:0] c, logic eot);
        step_tokens = 0;
        if (eot)
        begin
            if (sc_state != SC_IDLE)
            begin
                flush_pending();
            end
            emit_tok(TC_EOF, 8'd0, 8'd0, NO_KEYWORD);
        end
        else if (sc_state != SC_IDLE)
        begin
            if (!absorb(c))
            begin
                flush_pending();
                begin_char(c);
            end
        end
        else
        begin
            begin_char(c);
        end
        if (step_tokens > 0)
        begin
            tokens_due[tokens_due.size() - 1].last = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic int gap_length();
        return ($urandom_range(99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26)
        begin
            return 8'("a" + r);
        end
        if (r < 52)
        begin
            return 8'("A" + r - 26);
        end
        return "_";
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(62);
        if (r < 10)
        begin
            return 8'("0" + r);
        end
        return rand_letter();
    endfunction

    // Send one word; entered just after a rising edge, returns at its accepting edge
    task automatic send_word(input logic [7:0] c, input logic eot);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? gap_length() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= c;
        end_of_text <= eot;
        do @(posedge clk); while (!in_ready);
        scan_word(c, eot);
        words_sent++;
        if (eot)
        begin
            ends_sent++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_word(s[i], 1'b0);
        end
    endtask

    task automatic send_name(input int len);
        send_word(rand_letter(), 1'b0);
        repeat (len - 1) send_word(rand_alnum(), 1'b0);
    endtask

    task automatic send_number(input int len);
        repeat (len) send_word(8'("0" + $urandom_range(9)), 1'b0);
    endtask

    // Hold the input off until every expected token has come out
    task automatic wait_for_tokens();
        @(negedge clk);
        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_names_and_numbers();
        send_text("else _Z9 007\n");
    endtask

    task automatic test_operators();
        send_text("a<<=b!=~c&&(d);{}");
    endtask

    // Carriage return, byte zero and high bytes all give error tokens
    task automatic test_unknown_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'h0D, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'hFF, 1'b0);
    endtask

    // Pending shift flushed by the end marker, then a repeated end and a lone > before an end
    task automatic test_end_cases();
        send_text("x<<");
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b1);
        send_text(">");
        send_word(8'h5A, 1'b1);
    endtask

    // Tokens longer than the length cap
    task automatic test_long_token();
        send_name(270);
        send_word(" ", 1'b0);
        send_number(300);
        send_word(8'hA5, 1'b1);
        wait_for_tokens();
    endtask

    // Mostly well-formed C fragments with random content, some noise
    task automatic test_random_text(input int n);
        int pick;
        int seg_end;
        for (int seg = 0; seg < 8; seg++)
        begin
            case (seg % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 35;
                default: idle_pct = 70;
            endcase
            seg_end = words_sent + n / 8;
            while (words_sent < seg_end)
            begin
                pick = $urandom_range(99);
                if (pick < 12)
                begin
                    send_text(kw_words[$urandom_range(6)]);
                end
                else if (pick < 28)
                begin
                    send_name(($urandom_range(199) == 0) ? $urandom_range(250, 300)
                                                         : $urandom_range(1, 8));
                end
                else if (pick < 40)
                begin
                    send_number($urandom_range(1, 6));
                end
                else if (pick < 70)
                begin
                    send_text(op_words[$urandom_range($size(op_words) - 1)]);
                end
                else if (pick < 90)
                begin
                    case ($urandom_range(2))
                        0:       send_word(" ", 1'b0);
                        1:       send_word("\t", 1'b0);
                        default: send_word("\n", 1'b0);
                    endcase
                end
                else if (pick < 96)
                begin
                    send_word(8'($urandom_range(255)), 1'b0);
                end
                else
                begin
                    send_word(8'($urandom_range(255)), 1'b1);
                end
            end
            if (seg == 3)
            begin
                wait_for_tokens();
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ---------------------------------------------------------------
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(99) < idle_pct)
        begin
            out_ready <= 1'b0;
            stall_left = gap_length() - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tok_t want;
        tok_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.cls   = tok_class_t'(token_class);
            got.len   = token_length;
            got.first = first_byte;
            got.kw    = keyword_number;
            got.line  = line_number;
            got.last  = last_of_run;
            if (tokens_due.size() == 0)
            begin
                note_failure($sformatf("unexpected token cls=%0d len=%0d first=%02h",
                                       got.cls, got.len, got.first));
            end
            else
            begin
                want = tokens_due.pop_front();
                tokens_checked++;
                if (got.cls !== want.cls || got.len !== want.len ||
                    got.first !== want.first || got.kw !== want.kw ||
                    got.line !== want.line || got.last !== want.last)
                begin
                    note_failure({"token mismatch ",
                        $sformatf("exp cls=%0d len=%0d first=%02h kw=%0d line=%0d last=%0b",
                                  want.cls, want.len, want.first, want.kw, want.line,
                                  want.last),
                        $sformatf(" got cls=%0d len=%0d first=%02h kw=%0d line=%0d last=%0b",
                                  got.cls, got.len, got.first, got.kw, got.line,
                                  got.last)});
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        int spin;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_names_and_numbers();
        test_operators();
        test_unknown_bytes();
        test_end_cases();
        test_long_token();
        test_random_text(1400);

        // Drain, then allow for the scanner pipeline
        @(negedge clk);
        in_valid <= 1'b0;
        for (spin = 0; spin < 20000 && tokens_due.size() != 0; spin++)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (tokens_due.size() != 0)
        begin
            note_failure($sformatf("%0d expected tokens never arrived", tokens_due.size()));
        end

        $display("Scanned %0d words (%0d end markers) under varied stalls; %0d tokens compared.",
                 words_sent, ends_sent, tokens_checked);
        $display("Covered keywords, names, integers, operators, stray bytes and capped lengths.");
        if (failures == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d failures", failures);
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #3_000_000;
        $display("Run did not finish in the allowed period");
        $display("== FAIL ==");
        $finish;
    end

endmodule
